// ===== rtl/eatrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Euler angle rotation matrix package
// Shared widths, convention codes, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package eatrm_pkg;

   localparam int AngleWidth    = 16;
   localparam int EntryWidth    = 16;
   localparam int TrigWidth     = 17;   // Q15 trig value, range -32768..32768
   localparam int CordicSteps   = 16;
   localparam int CordicWidth   = 34;   // x, y: Q30 plus guard bits
   localparam int ZWidth        = 32;
   localparam int ConvWidth     = 2;

   // Input register, CORDIC steps, trig output register and four combiner stages.
   localparam int PipeLatency   = CordicSteps + 6;

   localparam logic [ConvWidth-1:0] CONV_XYZ   = 2'd0;
   localparam logic [ConvWidth-1:0] CONV_KOCKS = 2'd1;
   localparam logic [ConvWidth-1:0] CONV_BUNGE = 2'd2;

   localparam logic signed [CordicWidth-1:0] CordicGain = 34'sd652032874;

   typedef logic [AngleWidth-1:0]         angle_type;
   typedef logic signed [EntryWidth-1:0]  entry_type;
   typedef logic signed [TrigWidth-1:0]   trig_type;
   typedef logic signed [CordicWidth-1:0] cxy_type;
   typedef logic signed [ZWidth-1:0]      cz_type;

   typedef struct packed {
      trig_type c1, s1, c2, s2, c3, s3;
   } trig_set_type;

   function automatic cz_type atan_lookup(input int unsigned idx);
      cz_type v;
      case (idx)
         0: v = 32'sh20000000;
         1: v = 32'sh12E4051E;
         2: v = 32'sh09FB385B;
         3: v = 32'sh051111D4;
         4: v = 32'sh028B0D43;
         5: v = 32'sh0145D7E1;
         6: v = 32'sh00A2F61E;
         7: v = 32'sh00517C55;
         8: v = 32'sh0028BE53;
         9: v = 32'sh00145F2F;
         10: v = 32'sh000A2F98;
         11: v = 32'sh000517CC;
         12: v = 32'sh00028BE6;
         13: v = 32'sh000145F3;
         14: v = 32'sh0000A2FA;
         15: v = 32'sh0000517D;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/eatrm_if.sv =====
// ----------------------------------------------------------------------------
// Euler angle rotation matrix channels
// Valid/ready interfaces for the angle, matrix and control channels.
// ----------------------------------------------------------------------------
interface eatrm_req_if import eatrm_pkg::*; ();
   logic      valid;
   logic      ready;
   angle_type first_angle;
   angle_type second_angle;
   angle_type third_angle;
   modport source (output valid, first_angle, second_angle, third_angle, input ready);
   modport sink   (input valid, first_angle, second_angle, third_angle, output ready);
endinterface

interface eatrm_rsp_if import eatrm_pkg::*; ();
   logic      valid;
   logic      ready;
   entry_type entry_r0c0, entry_r0c1, entry_r0c2;
   entry_type entry_r1c0, entry_r1c1, entry_r1c2;
   entry_type entry_r2c0, entry_r2c1, entry_r2c2;
   modport source (output valid, entry_r0c0, entry_r0c1, entry_r0c2, entry_r1c0,
                   entry_r1c1, entry_r1c2, entry_r2c0, entry_r2c1, entry_r2c2,
                   input ready);
   modport sink   (input valid, entry_r0c0, entry_r0c1, entry_r0c2, entry_r1c0,
                   entry_r1c1, entry_r1c2, entry_r2c0, entry_r2c1, entry_r2c2,
                   output ready);
endinterface

interface eatrm_csr_if import eatrm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ConvWidth-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/eatrm_cordic.sv =====
// ----------------------------------------------------------------------------
// Euler angle rotation matrix CORDIC
// Pipelined 16-step CORDIC giving cosine and sine of one binary angle.
// One step per stage, advancing when en is high.
// ----------------------------------------------------------------------------
module eatrm_cordic import eatrm_pkg::*; (
   input  logic      clock,
   input  logic      en,
   input  angle_type angle,
   output trig_type  cos_out,
   output trig_type  sin_out
);

   cxy_type        x_ff [CordicSteps+1];
   cxy_type        y_ff [CordicSteps+1];
   cz_type         z_ff [CordicSteps+1];
   logic     [1:0] q_ff [CordicSteps+1];
   logic           zero_ff [CordicSteps+1];
   trig_type       cos_ff, sin_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= CordicGain;
         y_ff[0]    <= '0;
         z_ff[0]    <= {2'b00, angle[13:0], 16'd0};
         q_ff[0]    <= angle[15:14];
         zero_ff[0] <= (angle[13:0] == '0);
      end
   end

   for (genvar i = 0; i < CordicSteps; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[i+1]    <= q_ff[i];
            zero_ff[i+1] <= zero_ff[i];
            if (!z_ff[i][ZWidth-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_lookup(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_lookup(i);
            end
         end
      end
   end

   function automatic trig_type round_q15(input cxy_type v);
      cxy_type r;
      r = (v + cxy_type'(16384)) >>> 15;
      if (r > cxy_type'(32768))       return trig_type'(32768);
      else if (r < -cxy_type'(32768)) return trig_type'(-32768);
      else                            return r[TrigWidth-1:0];
   endfunction

   trig_type c0_in, s0_in, cos_in, sin_in;

   always_comb begin
      if (zero_ff[CordicSteps]) begin
         c0_in = trig_type'(32768);
         s0_in = '0;
      end else begin
         c0_in = round_q15(x_ff[CordicSteps]);
         s0_in = round_q15(y_ff[CordicSteps]);
      end
      case (q_ff[CordicSteps])
         2'd0: begin cos_in = c0_in;  sin_in = s0_in;  end
         2'd1: begin cos_in = -s0_in; sin_in = c0_in;  end
         2'd2: begin cos_in = -c0_in; sin_in = -s0_in; end
         default: begin cos_in = s0_in; sin_in = -c0_in; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ===== rtl/eatrm_matrix.sv =====
// ----------------------------------------------------------------------------
// Euler angle rotation matrix combiner
// Four-stage products and sums that form the nine Q15 matrix entries.
// ----------------------------------------------------------------------------
module eatrm_matrix import eatrm_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [ConvWidth-1:0] conv,
   input  trig_set_type         trig,
   output entry_type            entry [9]
);

   typedef logic signed [33:0] p2_type;   // Q30 product of two trig values
   typedef logic signed [50:0] p3_type;   // Q45 product of three
   typedef logic signed [51:0] sum_type;

   // Stage 1: all two-way products of interest.
   p2_type c1c2_ff, c1c3_ff, c1s2_ff, c1s3_ff, s1c2_ff, s1c3_ff, s1s2_ff, s1s3_ff;
   p2_type c2c3_ff, c2s3_ff, s2c3_ff, s2s3_ff;
   trig_type c2_ff, s2_ff, c3_ff, s3_ff;
   logic [ConvWidth-1:0] conv1_ff, conv2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c1c2_ff <= trig.c1 * trig.c2;  c1c3_ff <= trig.c1 * trig.c3;
         c1s2_ff <= trig.c1 * trig.s2;  c1s3_ff <= trig.c1 * trig.s3;
         s1c2_ff <= trig.s1 * trig.c2;  s1c3_ff <= trig.s1 * trig.c3;
         s1s2_ff <= trig.s1 * trig.s2;  s1s3_ff <= trig.s1 * trig.s3;
         c2c3_ff <= trig.c2 * trig.c3;  c2s3_ff <= trig.c2 * trig.s3;
         s2c3_ff <= trig.s2 * trig.c3;  s2s3_ff <= trig.s2 * trig.s3;
         c2_ff <= trig.c2; s2_ff <= trig.s2; c3_ff <= trig.c3; s3_ff <= trig.s3;
         conv1_ff <= conv;
      end
   end

   // Stage 2: three-way products, scaled two-way and trig terms, all in Q45.
   p3_type c1c2c3_ff, c1c2s3_ff, s1c2c3_ff, s1c2s3_ff;
   p3_type c1s2c3_ff, c1s2s3_ff, s1s2c3_ff, s1s2s3_ff;
   p3_type t_c1c2_ff, t_c1c3_ff, t_c1s2_ff, t_c1s3_ff, t_s1c2_ff, t_s1c3_ff;
   p3_type t_s1s2_ff, t_s1s3_ff, t_c2c3_ff, t_c2s3_ff, t_s2c3_ff, t_s2s3_ff;
   p3_type t_c2_ff, t_s2_ff;

   function automatic p3_type sc2(input p2_type v);
      return p3_type'(v) <<< 15;
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         c1c2c3_ff <= c1c2_ff * c3_ff;  c1c2s3_ff <= c1c2_ff * s3_ff;
         s1c2c3_ff <= s1c2_ff * c3_ff;  s1c2s3_ff <= s1c2_ff * s3_ff;
         c1s2c3_ff <= c1s2_ff * c3_ff;  c1s2s3_ff <= c1s2_ff * s3_ff;
         s1s2c3_ff <= s1s2_ff * c3_ff;  s1s2s3_ff <= s1s2_ff * s3_ff;
         t_c1c2_ff <= sc2(c1c2_ff); t_c1c3_ff <= sc2(c1c3_ff);
         t_c1s2_ff <= sc2(c1s2_ff); t_c1s3_ff <= sc2(c1s3_ff);
         t_s1c2_ff <= sc2(s1c2_ff); t_s1c3_ff <= sc2(s1c3_ff);
         t_s1s2_ff <= sc2(s1s2_ff); t_s1s3_ff <= sc2(s1s3_ff);
         t_c2c3_ff <= sc2(c2c3_ff); t_c2s3_ff <= sc2(c2s3_ff);
         t_s2c3_ff <= sc2(s2c3_ff); t_s2s3_ff <= sc2(s2s3_ff);
         t_c2_ff   <= p3_type'(c2_ff) <<< 30;
         t_s2_ff   <= p3_type'(s2_ff) <<< 30;
         conv2_ff  <= conv1_ff;
      end
   end

   // Stage 3: select terms per convention and add.
   sum_type m_in [9];
   sum_type m_ff [9];

   function automatic sum_type ex(input p3_type v);
      return sum_type'(v);
   endfunction

   always_comb begin
      for (int k = 0; k < 9; k++) m_in[k] = '0;
      case (conv2_ff)
         CONV_XYZ: begin
            m_in[0] = ex(t_c2c3_ff);
            m_in[1] = -ex(t_c2s3_ff);
            m_in[2] = ex(t_s2_ff);
            m_in[3] = ex(t_c1s3_ff) + ex(s1s2c3_ff);
            m_in[4] = ex(t_c1c3_ff) - ex(s1s2s3_ff);
            m_in[5] = -ex(t_s1c2_ff);
            m_in[6] = ex(t_s1s3_ff) - ex(c1s2c3_ff);
            m_in[7] = ex(t_s1c3_ff) + ex(c1s2s3_ff);
            m_in[8] = ex(t_c1c2_ff);
         end
         CONV_KOCKS: begin
            m_in[0] = -ex(c1c2c3_ff) - ex(t_s1s3_ff);
            m_in[1] = ex(t_s1c3_ff) - ex(c1c2s3_ff);
            m_in[2] = ex(t_c1s2_ff);
            m_in[3] = ex(t_c1s3_ff) - ex(s1c2c3_ff);
            m_in[4] = -ex(t_c1c3_ff) - ex(s1c2s3_ff);
            m_in[5] = ex(t_s1s2_ff);
            m_in[6] = ex(t_s2c3_ff);
            m_in[7] = ex(t_s2s3_ff);
            m_in[8] = ex(t_c2_ff);
         end
         CONV_BUNGE: begin
            m_in[0] = ex(t_c1c3_ff) - ex(s1c2s3_ff);
            m_in[1] = -ex(t_c1s3_ff) - ex(s1c2c3_ff);
            m_in[2] = ex(t_s1s2_ff);
            m_in[3] = ex(t_s1c3_ff) + ex(c1c2s3_ff);
            m_in[4] = ex(c1c2c3_ff) - ex(t_s1s3_ff);
            m_in[5] = -ex(t_c1s2_ff);
            m_in[6] = ex(t_s2s3_ff);
            m_in[7] = ex(t_s2c3_ff);
            m_in[8] = ex(t_c2_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) m_ff[k] <= m_in[k];
      end
   end

   // Stage 4: round to Q15 and saturate.
   entry_type e_ff [9];
   sum_type   r_in [9];

   always_comb begin
      for (int k = 0; k < 9; k++) r_in[k] = (m_ff[k] + (sum_type'(1) <<< 29)) >>> 30;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            if (r_in[k] > sum_type'(32767))       e_ff[k] <= 16'sh7FFF;
            else if (r_in[k] < -sum_type'(32768)) e_ff[k] <= 16'sh8000;
            else                                  e_ff[k] <= r_in[k][EntryWidth-1:0];
         end
      end
   end

   assign entry = e_ff;

endmodule

// ===== rtl/euler_angles_to_rotation_matrix_unit.sv =====
// Each transaction passes every CORDIC and combiner stage to the output.
// Throughput: one transaction per cycle; the whole pipeline advances together
// and holds while the output is stalled, so a stall loses and repeats nothing.
// The output register frees as it is taken, so input and output can both move.
// Reset (synchronous, active high) clears all valid bits and sets the
// convention to X-Y-Z.
// ----------------------------------------------------------------------------
// Euler angles to rotation matrix unit
// Three pipelined CORDICs feed a four-stage product and sum combiner.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix_unit import eatrm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   eatrm_req_if.sink   req,
   eatrm_rsp_if.source rsp,
   eatrm_csr_if.sink   csr
);

   logic [ConvWidth-1:0]   conv_ff;
   logic [PipeLatency-1:0] valid_ff;
   logic                   en;

   // Advance whenever the last stage is empty or being taken.
   assign en        = !valid_ff[PipeLatency-1] || rsp.ready;
   assign req.ready = en;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_ff  <= CONV_XYZ;
         valid_ff <= '0;
      end else begin
         if (csr.valid) conv_ff <= csr.data;
         if (en) valid_ff <= {valid_ff[PipeLatency-2:0], req.valid};
      end
   end

   trig_set_type trig;
   eatrm_cordic u_c1 (.clock, .en, .angle(req.first_angle),
                      .cos_out(trig.c1), .sin_out(trig.s1));
   eatrm_cordic u_c2 (.clock, .en, .angle(req.second_angle),
                      .cos_out(trig.c2), .sin_out(trig.s2));
   eatrm_cordic u_c3 (.clock, .en, .angle(req.third_angle),
                      .cos_out(trig.c3), .sin_out(trig.s3));

   entry_type entry [9];
   eatrm_matrix u_matrix (.clock, .en, .conv(conv_ff), .trig, .entry);

   assign rsp.valid      = valid_ff[PipeLatency-1];
   assign rsp.entry_r0c0 = entry[0];
   assign rsp.entry_r0c1 = entry[1];
   assign rsp.entry_r0c2 = entry[2];
   assign rsp.entry_r1c0 = entry[3];
   assign rsp.entry_r1c1 = entry[4];
   assign rsp.entry_r1c2 = entry[5];
   assign rsp.entry_r2c0 = entry[6];
   assign rsp.entry_r2c1 = entry[7];
   assign rsp.entry_r2c2 = entry[8];

endmodule

// ===== rtl/eatrm_checker.sv =====
// ----------------------------------------------------------------------------
// Euler angle rotation matrix checker
// Port-level assertions on the top level, attached by bind.
// ----------------------------------------------------------------------------
module eatrm_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped under stall");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("result right after reset");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("input stalled with empty output");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready) else $error("control port not ready");

endmodule

bind euler_angles_to_rotation_matrix_unit eatrm_checker u_checker (
   .clock(clock), .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .csr_ready(csr.ready)
);
